>>> hdl/prqs_pkg.sv
package prqs_pkg;

   localparam int unsigned NumLevelsDefault = 32;
   localparam int unsigned NumTasksDefault  = 64;
   localparam int unsigned FuncWidth        = 2;
   localparam int unsigned TaskIdWidth      = 6;
   localparam int unsigned PrioWidth        = 8;

   typedef enum logic [1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_SELECT = 2'd1,
      FUNC_ROTATE = 2'd2,
      FUNC_REMOVE = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD,
      ST_DECIDE,
      ST_ADD_LINK,
      ST_ROT_RD,
      ST_ROT_WR,
      ST_REM_WALK,
      ST_REM_NEXT,
      ST_REM_FIX,
      ST_RESP
   } state_type;

endpackage

>>> hdl/prqs_link_mem.sv
module prqs_link_mem #(
   parameter int unsigned NUM_TASKS = prqs_pkg::NumTasksDefault,
   parameter int unsigned TW        = $clog2(NUM_TASKS)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [TW-1:0] wr_addr,
   input  logic [TW-1:0] wr_data,
   input  logic [TW-1:0] rd_addr,
   output logic [TW-1:0] rd_data
);

   logic [TW-1:0] mem [NUM_TASKS];
   logic [TW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/prqs_level_mem.sv
module prqs_level_mem #(
   parameter int unsigned NUM_LEVELS = prqs_pkg::NumLevelsDefault,
   parameter int unsigned LW         = $clog2(NUM_LEVELS),
   parameter int unsigned TW         = 6
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [LW-1:0]   wr_addr,
   input  logic [2*TW-1:0] wr_data,
   input  logic [LW-1:0]   rd_addr,
   output logic [2*TW-1:0] rd_data
);

   logic [2*TW-1:0] mem [NUM_LEVELS];
   logic [2*TW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/priority_ready_queue_scheduler_top.sv
// priority ready queue scheduler
// keeps one fifo list of task ids per priority level (0 highest), stored as
// head/tail pairs in a level memory and next links in a link memory
// req channel: req_valid/req_stall with req_func, req_task_id, req_prio_level
// func 0 add, 1 select, 2 rotate, 3 remove
// rsp channel: rsp_valid/rsp_stall with rsp_ok, rsp_chosen_task
// exactly one rsp item per req item; chosen_task is nonzero only for a
// successful select
// one item at a time: a new req is taken only once the last rsp is taken;
// each item reads its level entry, then add writes the new tail (and links
// the old tail for a non-empty list), rotate moves the head to the tail,
// and remove walks the list through the one-read-port link memory
// reset clears counts, queued bits and the non-empty bitmap;
// head, tail and link memories need no clearing, so items are taken right
// after reset
// while rsp is stalled the result is held in its register and req_stall
// stays high until the result is taken
module priority_ready_queue_scheduler_top #(
   parameter int unsigned NUM_LEVELS = prqs_pkg::NumLevelsDefault,
   parameter int unsigned NUM_TASKS  = prqs_pkg::NumTasksDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [prqs_pkg::FuncWidth-1:0] req_func,
   input  logic [prqs_pkg::TaskIdWidth-1:0] req_task_id,
   input  logic [prqs_pkg::PrioWidth-1:0] req_prio_level,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_ok,
   output logic [prqs_pkg::TaskIdWidth-1:0] rsp_chosen_task
);

   localparam int unsigned IW = prqs_pkg::TaskIdWidth;
   localparam int unsigned PW = prqs_pkg::PrioWidth;
   localparam int unsigned TW = $clog2(NUM_TASKS);
   localparam int unsigned LW = $clog2(NUM_LEVELS);
   localparam int unsigned CW = $clog2(NUM_TASKS + 1);

   prqs_pkg::state_type state_ff, state_in;
   prqs_pkg::func_type  func_ff, func_in;
   logic [TW-1:0]  task_ff, task_in;
   logic [LW-1:0]  lvl_ff, lvl_in;
   logic           range_ok_ff, range_ok_in;
   logic [TW-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [TW-1:0]  cur_ff, cur_in, prev_ff, prev_in;
   logic           has_prev_ff, has_prev_in;
   logic [CW-1:0]  walk_ff, walk_in;
   logic           ok_ff, ok_in;
   logic [IW-1:0]  chosen_ff, chosen_in;
   logic [CW-1:0]  count_ff [NUM_LEVELS];
   logic [NUM_TASKS-1:0]  queued_ff;
   logic [NUM_LEVELS-1:0] map_ff;

   logic          lk_we;
   logic [TW-1:0] lk_wa, lk_wd, lk_ra, lk_rd;
   logic          lv_we;
   logic [LW-1:0] lv_wa, lv_ra;
   logic [2*TW-1:0] lv_wd, lv_rd;

   logic          cnt_inc, cnt_dec, q_set, q_clr;
   logic [LW-1:0] first_lvl;
   logic          any_lvl;
   logic [CW-1:0] cnt_cur;

   prqs_link_mem #(.NUM_TASKS(NUM_TASKS), .TW(TW)) u_link (
      .clock(clock), .wr_en(lk_we), .wr_addr(lk_wa), .wr_data(lk_wd),
      .rd_addr(lk_ra), .rd_data(lk_rd)
   );

   prqs_level_mem #(.NUM_LEVELS(NUM_LEVELS), .LW(LW), .TW(TW)) u_level (
      .clock(clock), .wr_en(lv_we), .wr_addr(lv_wa), .wr_data(lv_wd),
      .rd_addr(lv_ra), .rd_data(lv_rd)
   );

   always_comb begin
      first_lvl = '0;
      any_lvl   = 1'b0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (map_ff[i]) begin
            first_lvl = LW'(i);
            any_lvl   = 1'b1;
         end
      end
   end

   assign cnt_cur = count_ff[lvl_ff];

   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      task_in     = task_ff;
      lvl_in      = lvl_ff;
      range_ok_in = range_ok_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      has_prev_in = has_prev_ff;
      walk_in     = walk_ff;
      ok_in       = ok_ff;
      chosen_in   = chosen_ff;
      lk_we = 1'b0;
      lk_wa = cur_ff;
      lk_wd = '0;
      lk_ra = cur_ff;
      lv_we = 1'b0;
      lv_wa = lvl_ff;
      lv_wd = {head_ff, tail_ff};
      lv_ra = lvl_ff;
      cnt_inc = 1'b0;
      cnt_dec = 1'b0;
      q_set   = 1'b0;
      q_clr   = 1'b0;
      unique case (state_ff)
         prqs_pkg::ST_IDLE: begin
            if (req_valid) begin
               func_in     = prqs_pkg::func_type'(req_func);
               task_in     = TW'(req_task_id);
               lvl_in      = LW'(req_prio_level);
               range_ok_in = (PW'(req_prio_level) < PW'(NUM_LEVELS))
                  && (IW'(req_task_id) <= IW'(NUM_TASKS - 1));
               ok_in       = 1'b0;
               chosen_in   = '0;
               state_in    = prqs_pkg::ST_RD;
            end
         end
         prqs_pkg::ST_RD: begin
            if (func_ff == prqs_pkg::FUNC_SELECT) begin
               lvl_in = first_lvl;
               lv_ra  = first_lvl;
            end
            state_in = prqs_pkg::ST_DECIDE;
         end
         prqs_pkg::ST_DECIDE: begin
            head_in  = lv_rd[2*TW-1:TW];
            tail_in  = lv_rd[TW-1:0];
            state_in = prqs_pkg::ST_RESP;
            unique case (func_ff)
               prqs_pkg::FUNC_ADD: begin
                  if (range_ok_ff && !queued_ff[task_ff]) begin
                     ok_in   = 1'b1;
                     cnt_inc = 1'b1;
                     q_set   = 1'b1;
                     lk_we   = 1'b1;
                     lk_wa   = task_ff;
                     lk_wd   = '0;
                     lv_we   = 1'b1;
                     if (cnt_cur == '0) begin
                        lv_wd = {task_ff, task_ff};
                     end else begin
                        lv_wd    = {lv_rd[2*TW-1:TW], task_ff};
                        tail_in  = lv_rd[TW-1:0];
                        state_in = prqs_pkg::ST_ADD_LINK;
                     end
                  end
               end
               prqs_pkg::FUNC_SELECT: begin
                  if (any_lvl) begin
                     ok_in     = 1'b1;
                     chosen_in = IW'(lv_rd[2*TW-1:TW]);
                  end
               end
               prqs_pkg::FUNC_ROTATE: begin
                  if (range_ok_ff && cnt_cur > CW'(1)) begin
                     lk_ra    = lv_rd[2*TW-1:TW];
                     state_in = prqs_pkg::ST_ROT_RD;
                  end
               end
               prqs_pkg::FUNC_REMOVE: begin
                  if (range_ok_ff && queued_ff[task_ff]) begin
                     cur_in      = lv_rd[2*TW-1:TW];
                     lk_ra       = lv_rd[2*TW-1:TW];
                     prev_in     = '0;
                     has_prev_in = 1'b0;
                     walk_in     = cnt_cur;
                     state_in    = prqs_pkg::ST_REM_WALK;
                  end
               end
               default: ;
            endcase
         end
         prqs_pkg::ST_ADD_LINK: begin
            lk_we    = 1'b1;
            lk_wa    = tail_ff;
            lk_wd    = task_ff;
            state_in = prqs_pkg::ST_RESP;
         end
         prqs_pkg::ST_ROT_RD: begin
            lk_we    = 1'b1;
            lk_wa    = head_ff;
            lk_wd    = '0;
            lv_we    = 1'b1;
            lv_wd    = {lk_rd, head_ff};
            state_in = prqs_pkg::ST_ROT_WR;
         end
         prqs_pkg::ST_ROT_WR: begin
            lk_we    = 1'b1;
            lk_wa    = tail_ff;
            lk_wd    = head_ff;
            ok_in    = 1'b1;
            state_in = prqs_pkg::ST_RESP;
         end
         prqs_pkg::ST_REM_WALK: begin
            // link of cur is on lk_rd now
            if (walk_ff == '0) begin
               state_in = prqs_pkg::ST_RESP;
            end else if (cur_ff == task_ff) begin
               ok_in    = 1'b1;
               cnt_dec  = 1'b1;
               q_clr    = 1'b1;
               lk_we    = 1'b1;
               lk_wa    = cur_ff;
               lk_wd    = '0;
               head_in  = (has_prev_ff) ? head_ff : lk_rd;
               tail_in  = (tail_ff == cur_ff) ? prev_ff : tail_ff;
               cur_in   = lk_rd;
               state_in = prqs_pkg::ST_REM_FIX;
            end else begin
               prev_in     = cur_ff;
               has_prev_in = 1'b1;
               cur_in      = lk_rd;
               walk_in     = walk_ff - CW'(1);
               state_in    = prqs_pkg::ST_REM_NEXT;
            end
         end
         prqs_pkg::ST_REM_NEXT: begin
            lk_ra    = cur_ff;
            state_in = prqs_pkg::ST_REM_WALK;
         end
         prqs_pkg::ST_REM_FIX: begin
            // cur holds the removed task's successor
            if (has_prev_ff) begin
               lk_we = 1'b1;
               lk_wa = prev_ff;
               lk_wd = cur_ff;
            end
            lv_we    = 1'b1;
            lv_wd    = {head_ff, tail_ff};
            state_in = prqs_pkg::ST_RESP;
         end
         prqs_pkg::ST_RESP: begin
            if (!rsp_stall) begin
               state_in = prqs_pkg::ST_IDLE;
            end
         end
         default: state_in = prqs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= prqs_pkg::ST_IDLE;
         queued_ff <= '0;
         map_ff    <= '0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (q_set) begin
            queued_ff[task_ff] <= 1'b1;
         end
         if (q_clr) begin
            queued_ff[task_ff] <= 1'b0;
         end
         if (cnt_inc) begin
            count_ff[lvl_ff] <= cnt_cur + CW'(1);
            map_ff[lvl_ff]   <= 1'b1;
         end
         if (cnt_dec) begin
            count_ff[lvl_ff] <= cnt_cur - CW'(1);
            if (cnt_cur == CW'(1)) begin
               map_ff[lvl_ff] <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      task_ff     <= task_in;
      lvl_ff      <= lvl_in;
      range_ok_ff <= range_ok_in;
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      has_prev_ff <= has_prev_in;
      walk_ff     <= walk_in;
      ok_ff       <= ok_in;
      chosen_ff   <= chosen_in;
   end

   assign req_stall       = (state_ff != prqs_pkg::ST_IDLE);
   assign rsp_valid       = (state_ff == prqs_pkg::ST_RESP);
   assign rsp_ok          = ok_ff;
   assign rsp_chosen_task = chosen_ff;

endmodule

>>> tb/tb_top.sv
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LEVELS = 32;
   localparam int unsigned TASKS = 64;
   localparam int unsigned STALL_LIMIT = 20000;

   class sched_scoreboard;
      logic [5:0] head_of[LEVELS];
      logic [5:0] tail_of[LEVELS];
      int unsigned count_of[LEVELS];
      logic [LEVELS-1:0] busy_levels;
      logic [5:0] link_of[TASKS];
      bit queued[TASKS];
      logic ok_q[$];
      logic [5:0] chosen_q[$];
      int errors;

      function new();
         busy_levels = '0;
         errors = 0;
         foreach (count_of[i]) count_of[i] = 0;
         foreach (queued[i]) queued[i] = 0;
         foreach (head_of[i]) begin
            head_of[i] = '0;
            tail_of[i] = '0;
         end
         foreach (link_of[i]) link_of[i] = '0;
      endfunction

      function void note_item(prqs_pkg::func_type f, logic [5:0] t, logic [7:0] lvl);
         logic ok;
         logic [5:0] chosen;
         logic [5:0] cur;
         logic [5:0] prev;
         logic first;
         logic found;
         ok = 0;
         chosen = '0;
         prev = '0;
         first = 1;
         found = 0;
         case (f)
            prqs_pkg::FUNC_ADD: begin
               if (lvl < LEVELS && !queued[t]) begin
                  link_of[t] = '0;
                  if (count_of[lvl] != 0) link_of[tail_of[lvl]] = t;
                  else head_of[lvl] = t;
                  tail_of[lvl] = t;
                  count_of[lvl]++;
                  busy_levels[lvl] = 1;
                  queued[t] = 1;
                  ok = 1;
               end
            end
            prqs_pkg::FUNC_SELECT: begin
               for (int l = LEVELS - 1; l >= 0; l--)
                  if (busy_levels[l]) begin
                     ok = 1;
                     chosen = head_of[l];
                  end
            end
            prqs_pkg::FUNC_ROTATE: begin
               if (lvl < LEVELS && count_of[lvl] > 1) begin
                  cur = head_of[lvl];
                  head_of[lvl] = link_of[cur];
                  link_of[cur] = '0;
                  link_of[tail_of[lvl]] = cur;
                  tail_of[lvl] = cur;
                  ok = 1;
               end
            end
            default: begin
               if (lvl < LEVELS && queued[t]) begin
                  cur = head_of[lvl];
                  for (int i = 0; i < count_of[lvl]; i++) begin
                     if (cur == t) begin
                        found = 1;
                        break;
                     end
                     prev = cur;
                     first = 0;
                     cur = link_of[cur];
                  end
                  if (found) begin
                     if (!first) link_of[prev] = link_of[cur];
                     else head_of[lvl] = link_of[cur];
                     if (tail_of[lvl] == cur) tail_of[lvl] = prev;
                     link_of[cur] = '0;
                     queued[cur] = 0;
                     count_of[lvl]--;
                     if (count_of[lvl] == 0) busy_levels[lvl] = 0;
                     ok = 1;
                  end
               end
            end
         endcase
         ok_q.push_back(ok);
         chosen_q.push_back(chosen);
      endfunction

      task report(string what, int exp_v, int got_v);
         $display("mismatch on %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
         errors++;
      endtask

      task check_result(logic ok, logic [5:0] chosen);
         logic exp_ok;
         logic [5:0] exp_chosen;
         if (ok_q.size() == 0) begin
            report("unexpected result", 0, ok);
            return;
         end
         exp_ok = ok_q.pop_front();
         exp_chosen = chosen_q.pop_front();
         if (ok !== exp_ok) report("ok", exp_ok, ok);
         if (chosen !== exp_chosen) report("chosen_task", exp_chosen, chosen);
      endtask

      function int pending();
         return ok_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [prqs_pkg::FuncWidth-1:0] req_func;
   logic [prqs_pkg::TaskIdWidth-1:0] req_task_id;
   logic [prqs_pkg::PrioWidth-1:0] req_prio_level;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_ok;
   logic [prqs_pkg::TaskIdWidth-1:0] rsp_chosen_task;

   sched_scoreboard sb = new();
   int send_idle_pct;
   int recv_idle_pct;
   bit hold_rsp;
   int idle_cycles;

   priority_ready_queue_scheduler_top i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_task_id(req_task_id),
      .req_prio_level(req_prio_level),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_ok(rsp_ok),
      .rsp_chosen_task(rsp_chosen_task)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (req_valid && !req_stall) begin
         sb.note_item(prqs_pkg::func_type'(req_func), req_task_id, req_prio_level);
      end
      if (rsp_valid && !rsp_stall) sb.check_result(rsp_ok, rsp_chosen_task);
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_stall <= 0;
      else rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle_pct);
   end

   task automatic send_item(prqs_pkg::func_type f, logic [5:0] t, logic [7:0] lvl);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_func <= f;
      req_task_id <= t;
      req_prio_level <= lvl;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic random_item(int lvl_span);
      int pick;
      logic [7:0] lvl;
      pick = $urandom_range(99);
      lvl = ($urandom_range(19) == 0) ? 8'($urandom_range(255))
                                      : 8'($urandom_range(lvl_span));
      if (pick < 40) send_item(prqs_pkg::FUNC_ADD, 6'($urandom), lvl);
      else if (pick < 60) send_item(prqs_pkg::FUNC_SELECT, 6'($urandom), 8'($urandom));
      else if (pick < 75) send_item(prqs_pkg::FUNC_ROTATE, 6'($urandom), lvl);
      else send_item(prqs_pkg::FUNC_REMOVE, 6'($urandom), lvl);
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_func = '0;
      req_task_id = '0;
      req_prio_level = '0;
      rsp_stall = 0;
      hold_rsp = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      idle_cycles = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed
      send_item(prqs_pkg::FUNC_SELECT, 6'd0, 8'd0);
      send_item(prqs_pkg::FUNC_ROTATE, 6'd0, 8'd0);
      send_item(prqs_pkg::FUNC_REMOVE, 6'd5, 8'd0);
      send_item(prqs_pkg::FUNC_ADD, 6'd0, 8'd31);
      send_item(prqs_pkg::FUNC_ADD, 6'd63, 8'd31);
      send_item(prqs_pkg::FUNC_ADD, 6'd63, 8'd31);
      send_item(prqs_pkg::FUNC_ADD, 6'd7, 8'd32);
      send_item(prqs_pkg::FUNC_ADD, 6'd8, 8'd255);
      send_item(prqs_pkg::FUNC_SELECT, 6'd0, 8'd0);
      send_item(prqs_pkg::FUNC_ROTATE, 6'd0, 8'd31);
      send_item(prqs_pkg::FUNC_SELECT, 6'd0, 8'd0);
      send_item(prqs_pkg::FUNC_ADD, 6'd42, 8'd0);
      send_item(prqs_pkg::FUNC_ROTATE, 6'd0, 8'd0);
      send_item(prqs_pkg::FUNC_ROTATE, 6'd0, 8'd200);
      send_item(prqs_pkg::FUNC_SELECT, 6'd0, 8'd0);
      send_item(prqs_pkg::FUNC_REMOVE, 6'd42, 8'd31);
      send_item(prqs_pkg::FUNC_REMOVE, 6'd42, 8'd255);
      send_item(prqs_pkg::FUNC_REMOVE, 6'd42, 8'd0);
      send_item(prqs_pkg::FUNC_ADD, 6'd21, 8'd31);
      send_item(prqs_pkg::FUNC_REMOVE, 6'd63, 8'd31);
      send_item(prqs_pkg::FUNC_REMOVE, 6'd21, 8'd31);
      send_item(prqs_pkg::FUNC_REMOVE, 6'd0, 8'd31);
      send_item(prqs_pkg::FUNC_SELECT, 6'd0, 8'd0);

      // long receiver hold while items keep coming
      drain();
      hold_rsp = 1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_rsp = 0;
         end
         repeat (6) send_item(prqs_pkg::FUNC_ADD, 6'($urandom), 8'($urandom_range(3)));
      join
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 46 : 0;
         recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 36 : 0;
         for (int i = 0; i < 200; i++) random_item(phase == 2 ? 31 : 3);
         drain();
      end
      repeat (20) @(negedge clock);
      if (sb.pending() == 0 && sb.errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
